// ===== hdl/slpp_pkg.sv =====
// Shared types and constants for the status LED priority pattern block.
package slpp_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_FAULT_HOLD = 2'd1;
    localparam logic [1:0] REG_FLASH_HOLD = 2'd2;

    localparam logic [7:0]  BRIGHTNESS_RST = 8'd96;
    localparam logic [19:0] FAULT_HOLD_RST = 20'd120000;
    localparam logic [15:0] FLASH_HOLD_RST = 16'd250;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SET_BASE  = 3'd1;
    localparam logic [2:0] OP_LATCH     = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_ACTIVITY  = 3'd4;
    localparam logic [2:0] OP_BACKLOG   = 3'd5;

    localparam logic [3:0] ST_BOOTING     = 4'd0;
    localparam logic [3:0] ST_WIFI        = 4'd1;
    localparam logic [3:0] ST_DISCOVER    = 4'd2;
    localparam logic [3:0] ST_AUTH        = 4'd3;
    localparam logic [3:0] ST_SYNC        = 4'd4;
    localparam logic [3:0] ST_HEALTHY     = 4'd5;
    localparam logic [3:0] ST_BACKLOG     = 4'd6;
    localparam logic [3:0] ST_REMOTE_FAIL = 4'd7;
    localparam logic [3:0] ST_LINK_FAIL   = 4'd8;
    localparam logic [3:0] ST_FLAPPING    = 4'd9;
    localparam logic [3:0] ST_REPAIR      = 4'd10;
    localparam logic [3:0] ST_REBOOT      = 4'd11;
    localparam logic [3:0] ST_LOCAL_FAIL  = 4'd12;
    localparam logic [3:0] ST_FATAL       = 4'd13;
    localparam logic [3:0] ST_BLOCKED     = 4'd14;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] status_code;
        logic       backlog_flag;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] shown_status;
        logic       flash_active;
    } result_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic select;
        logic load_out;
    } ctrl_cmd_t;

endpackage

// ===== hdl/status_led_priority_pattern_core.sv =====
// Top level of the status LED priority pattern block.
// Each item (a 1 ms tick or one status event) passes through these steps: accept, apply the
// event to the status state, select the shown status and compute the pulse level, then
// scale by brightness into the result register; the scale step waits while the previous
// result is unread. One item is in work at a time. A finished result waits in its own
// register, so the next item is accepted while the previous result is still unread.
// Configuration registers sit at byte addresses 0 (brightness), 4 (fault hold, ms) and 8
// (flash hold, ms) and are to be written only while the block is idle; it does not enforce this.
module status_led_priority_pattern_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  slpp_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output slpp_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpp_pkg::ADDR_W-1:0] paddr,
    input  logic [slpp_pkg::DATA_W-1:0] pwdata,
    output logic [slpp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    slpp_pkg::ctrl_cmd_t cmd;
    logic [7:0]          brightness;
    logic [19:0]         fault_hold_ms;
    logic [15:0]         flash_hold_ms;

    slpp_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .brightness    (brightness),
        .fault_hold_ms (fault_hold_ms),
        .flash_hold_ms (flash_hold_ms)
    );

    slpp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    slpp_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .brightness    (brightness),
        .fault_hold_ms (fault_hold_ms),
        .flash_hold_ms (flash_hold_ms),
        .result        (result)
    );

endmodule

// ===== hdl/slpp_regs.sv =====
// APB-style configuration registers: brightness and hold times.
module slpp_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpp_pkg::ADDR_W-1:0] paddr,
    input  logic [slpp_pkg::DATA_W-1:0] pwdata,
    output logic [slpp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [7:0]                  brightness,
    output logic [19:0]                 fault_hold_ms,
    output logic [15:0]                 flash_hold_ms
);

    logic [7:0]  brightness_reg;
    logic [19:0] fault_hold_reg;
    logic [15:0] flash_hold_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= slpp_pkg::BRIGHTNESS_RST;
            fault_hold_reg <= slpp_pkg::FAULT_HOLD_RST;
            flash_hold_reg <= slpp_pkg::FLASH_HOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                slpp_pkg::REG_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                slpp_pkg::REG_FAULT_HOLD: fault_hold_reg <= pwdata[19:0];
                slpp_pkg::REG_FLASH_HOLD: flash_hold_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            slpp_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness_reg};
            slpp_pkg::REG_FAULT_HOLD: prdata = {12'd0, fault_hold_reg};
            slpp_pkg::REG_FLASH_HOLD: prdata = {16'd0, flash_hold_reg};
            default:                  prdata = '0;
        endcase
    end

    assign brightness    = brightness_reg;
    assign fault_hold_ms = fault_hold_reg;
    assign flash_hold_ms = flash_hold_reg;

endmodule

// ===== hdl/slpp_ctrl.sv =====
// Sequencer: accept, apply, select, scale, and result valid tracking.
module slpp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    output slpp_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_APPLY  = 4'b0010,
        S_SELECT = 4'b0100,
        S_SCALE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
                if (item_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// ===== hdl/slpp_dp.sv =====
// Datapath: status state, priority selection, pattern render and scaling.
module slpp_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  slpp_pkg::ctrl_cmd_t   cmd,
    input  slpp_pkg::item_t       item,
    input  logic [7:0]            brightness,
    input  logic [19:0]           fault_hold_ms,
    input  logic [15:0]           flash_hold_ms,
    output slpp_pkg::result_t     result
);

    localparam logic [10:0] SLOW_WRAP   = 11'd1999;
    localparam logic [8:0]  FAST_WRAP   = 9'd299;
    localparam logic [6:0]  PRIO_BACKLOG = 7'd55;
    localparam logic [12:0] RECIP_50     = 13'd5243;

    function automatic logic [6:0] prio_of(input logic [3:0] s);
        logic [6:0] p;
        begin
            unique case (s)
                slpp_pkg::ST_BOOTING:     p = 7'd20;
                slpp_pkg::ST_WIFI:        p = 7'd30;
                slpp_pkg::ST_DISCOVER:    p = 7'd40;
                slpp_pkg::ST_AUTH:        p = 7'd50;
                slpp_pkg::ST_SYNC:        p = 7'd60;
                slpp_pkg::ST_HEALTHY:     p = 7'd10;
                slpp_pkg::ST_BACKLOG:     p = 7'd55;
                slpp_pkg::ST_REMOTE_FAIL: p = 7'd80;
                slpp_pkg::ST_LINK_FAIL:   p = 7'd75;
                slpp_pkg::ST_FLAPPING:    p = 7'd74;
                slpp_pkg::ST_REPAIR:      p = 7'd72;
                slpp_pkg::ST_REBOOT:      p = 7'd90;
                slpp_pkg::ST_LOCAL_FAIL:  p = 7'd85;
                slpp_pkg::ST_FATAL:       p = 7'd100;
                slpp_pkg::ST_BLOCKED:     p = 7'd70;
                default:                  p = 7'd10;
            endcase
            return p;
        end
    endfunction

    function automatic logic is_fault(input logic [3:0] s);
        begin
            return (s == slpp_pkg::ST_REMOTE_FAIL) || (s == slpp_pkg::ST_LINK_FAIL) ||
                   (s == slpp_pkg::ST_REPAIR) || (s == slpp_pkg::ST_BLOCKED) ||
                   (s == slpp_pkg::ST_LOCAL_FAIL) || (s == slpp_pkg::ST_FATAL);
        end
    endfunction

    // v*b/255 for a 16-bit product: (x + 1 + (x >> 8)) >> 8
    function automatic logic [7:0] scale_ch(input logic [7:0] v, input logic [7:0] b);
        logic [15:0] x;
        logic [16:0] t;
        begin
            x = v * b;
            t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
            return t[15:8];
        end
    endfunction

    // item capture
    slpp_pkg::item_t item_reg;

    // status state
    logic [3:0]  base_reg,       base_next;
    logic        backlog_reg,    backlog_next;
    logic [3:0]  held_reg,       held_next;
    logic        fheld_reg,      fheld_next;
    logic [19:0] frem_reg,       frem_next;
    logic [15:0] flrem_reg,      flrem_next;
    logic [10:0] slow_reg,       slow_next;
    logic [8:0]  fast_reg,       fast_next;

    // select stage
    logic [3:0]  sel_reg,        sel_next;
    logic        flash_reg,      flash_next;
    logic [7:0]  pulse_reg,      pulse_next;
    logic        slow_on_reg,    slow_on_next;
    logic        fast_on_reg,    fast_on_next;
    logic        heart_on_reg,   heart_on_next;

    // scale stage
    slpp_pkg::result_t out_reg, out_next;

    logic [9:0]  tri_val;
    logic [13:0] tri9;
    logic [26:0] recip_prod;
    logic [7:0]  r_raw, g_raw, b_raw;
    logic [7:0]  bright_eff;

    // apply the event, then drop an expired non-fatal fault
    always_comb
    begin
        base_next    = base_reg;
        backlog_next = backlog_reg;
        held_next    = held_reg;
        fheld_next   = fheld_reg;
        frem_next    = frem_reg;
        flrem_next   = flrem_reg;
        slow_next    = slow_reg;
        fast_next    = fast_reg;
        unique case (item_reg.opcode)
            slpp_pkg::OP_TICK:
            begin
                slow_next = (slow_reg == SLOW_WRAP) ? 11'd0 : slow_reg + 11'd1;
                fast_next = (fast_reg == FAST_WRAP) ? 9'd0 : fast_reg + 9'd1;
                if (frem_reg != 20'd0)
                begin
                    frem_next = frem_reg - 20'd1;
                end
                if (flrem_reg != 16'd0)
                begin
                    flrem_next = flrem_reg - 16'd1;
                end
            end
            slpp_pkg::OP_SET_BASE:
            begin
                base_next = item_reg.status_code;
                if (item_reg.status_code == slpp_pkg::ST_FATAL)
                begin
                    held_next  = item_reg.status_code;
                    fheld_next = 1'b1;
                    frem_next  = fault_hold_ms;
                end
            end
            slpp_pkg::OP_LATCH:
            begin
                if (is_fault(item_reg.status_code))
                begin
                    held_next  = item_reg.status_code;
                    fheld_next = 1'b1;
                    frem_next  = fault_hold_ms;
                    if (item_reg.status_code == slpp_pkg::ST_FATAL)
                    begin
                        base_next = item_reg.status_code;
                    end
                end
            end
            slpp_pkg::OP_CLEAR:
            begin
                if (item_reg.status_code != slpp_pkg::ST_FATAL && fheld_reg &&
                    held_reg == item_reg.status_code)
                begin
                    fheld_next = 1'b0;
                end
            end
            slpp_pkg::OP_ACTIVITY:
            begin
                flrem_next = flash_hold_ms;
            end
            slpp_pkg::OP_BACKLOG:
            begin
                backlog_next = item_reg.backlog_flag;
            end
            default: ;
        endcase
        if (fheld_next && frem_next == 20'd0 && held_next != slpp_pkg::ST_FATAL)
        begin
            fheld_next = 1'b0;
        end
    end

    // select the shown status and the pattern phases
    always_comb
    begin
        sel_next = base_reg;
        if (base_reg == slpp_pkg::ST_HEALTHY && backlog_reg)
        begin
            sel_next = slpp_pkg::ST_BACKLOG;
        end
        if (fheld_reg && frem_reg != 20'd0 && prio_of(held_reg) > prio_of(sel_next))
        begin
            sel_next = held_reg;
        end
        flash_next    = (flrem_reg != 16'd0) && (prio_of(sel_next) <= PRIO_BACKLOG);
        slow_on_next  = (slow_reg < 11'd500) || (slow_reg >= 11'd1000 && slow_reg < 11'd1500);
        fast_on_next  = fast_reg < 9'd150;
        heart_on_next = (slow_reg < 11'd120) || (slow_reg >= 11'd260 && slow_reg < 11'd380);
        tri_val       = (slow_reg < 11'd1000) ? slow_reg[9:0]
                                              : 10'((11'd2000 - slow_reg));
        tri9          = {1'b0, tri_val, 3'b000} + {4'd0, tri_val};
        recip_prod    = tri9 * RECIP_50;
        pulse_next    = 8'(recip_prod[26:18]) + 8'd32;
    end

    // render the pattern and scale by brightness
    always_comb
    begin
        r_raw = 8'd0;
        g_raw = 8'd0;
        b_raw = 8'd0;
        if (flash_reg)
        begin
            g_raw = 8'd255;
        end
        else
        begin
            unique case (sel_reg)
                slpp_pkg::ST_BOOTING:
                begin
                    r_raw = pulse_reg;
                    g_raw = pulse_reg;
                    b_raw = pulse_reg;
                end
                slpp_pkg::ST_WIFI:     b_raw = slow_on_reg ? 8'd255 : 8'd0;
                slpp_pkg::ST_DISCOVER:
                begin
                    g_raw = pulse_reg;
                    b_raw = pulse_reg;
                end
                slpp_pkg::ST_AUTH:
                begin
                    g_raw = 8'd255;
                    b_raw = 8'd255;
                end
                slpp_pkg::ST_SYNC:
                begin
                    r_raw = pulse_reg;
                    b_raw = pulse_reg;
                end
                slpp_pkg::ST_HEALTHY:  g_raw = 8'd255;
                slpp_pkg::ST_BACKLOG:
                begin
                    r_raw = heart_on_reg ? 8'd255 : 8'd20;
                    g_raw = heart_on_reg ? 8'd160 : 8'd12;
                end
                slpp_pkg::ST_REMOTE_FAIL:
                begin
                    r_raw = slow_on_reg ? 8'd255 : 8'd0;
                    g_raw = slow_on_reg ? 8'd80 : 8'd0;
                end
                slpp_pkg::ST_LINK_FAIL:
                begin
                    r_raw = slow_on_reg ? 8'd255 : 8'd0;
                    g_raw = slow_on_reg ? 8'd220 : 8'd0;
                end
                slpp_pkg::ST_FLAPPING:
                begin
                    r_raw = fast_on_reg ? 8'd255 : 8'd0;
                    g_raw = fast_on_reg ? 8'd120 : 8'd40;
                    b_raw = fast_on_reg ? 8'd0 : 8'd90;
                end
                slpp_pkg::ST_REPAIR:
                begin
                    r_raw = slow_on_reg ? 8'd255 : 8'd0;
                    g_raw = slow_on_reg ? 8'd170 : 8'd0;
                end
                slpp_pkg::ST_REBOOT:   r_raw = fast_on_reg ? 8'd255 : 8'd0;
                slpp_pkg::ST_LOCAL_FAIL:
                begin
                    r_raw = slow_on_reg ? 8'd255 : 8'd0;
                    g_raw = slow_on_reg ? 8'd24 : 8'd0;
                end
                slpp_pkg::ST_FATAL:    r_raw = 8'd255;
                slpp_pkg::ST_BLOCKED:
                begin
                    r_raw = slow_on_reg ? 8'd255 : 8'd0;
                    b_raw = slow_on_reg ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
        end
        bright_eff            = (brightness == 8'd0) ? 8'd1 : brightness;
        out_next.red          = scale_ch(r_raw, bright_eff);
        out_next.green        = scale_ch(g_raw, bright_eff);
        out_next.blue         = scale_ch(b_raw, bright_eff);
        out_next.shown_status = sel_reg;
        out_next.flash_active = flash_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= slpp_pkg::ST_BOOTING;
            backlog_reg <= 1'b0;
            held_reg    <= 4'd0;
            fheld_reg   <= 1'b0;
            frem_reg    <= 20'd0;
            flrem_reg   <= 16'd0;
            slow_reg    <= 11'd0;
            fast_reg    <= 9'd0;
        end
        else if (cmd.apply)
        begin
            base_reg    <= base_next;
            backlog_reg <= backlog_next;
            held_reg    <= held_next;
            fheld_reg   <= fheld_next;
            frem_reg    <= frem_next;
            flrem_reg   <= flrem_next;
            slow_reg    <= slow_next;
            fast_reg    <= fast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.select)
        begin
            sel_reg      <= sel_next;
            flash_reg    <= flash_next;
            pulse_reg    <= pulse_next;
            slow_on_reg  <= slow_on_next;
            fast_on_reg  <= fast_on_next;
            heart_on_reg <= heart_on_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

// ===== tb/sv/status_led_priority_pattern_core_tb.sv =====
// Self-checking testbench for the status LED core: event and tick beats against a color predictor.
module status_led_priority_pattern_core_tb;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [3:0] ST_UNKNOWN = 4'd15;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 300;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_ready;
    slpp_pkg::item_t               item = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    slpp_pkg::result_t             result;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [slpp_pkg::ADDR_W-1:0]   paddr = '0;
    logic [slpp_pkg::DATA_W-1:0]   pwdata = '0;
    logic [slpp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic [7:0]  cfg_brightness = slpp_pkg::BRIGHTNESS_RST;
    logic [19:0] cfg_fault_hold = slpp_pkg::FAULT_HOLD_RST;
    logic [15:0] cfg_flash_hold = slpp_pkg::FLASH_HOLD_RST;
    logic [3:0]  base_st = slpp_pkg::ST_BOOTING;
    logic        backlog_on = 1'b0;
    logic [3:0]  fault_st = slpp_pkg::ST_BOOTING;
    logic        fault_on = 1'b0;
    logic [19:0] fault_left = '0;
    logic [15:0] flash_left = '0;
    int unsigned slow_ph = 0;
    int unsigned fast_ph = 0;

    logic [3:0] fault_codes [6] = '{slpp_pkg::ST_REMOTE_FAIL, slpp_pkg::ST_LINK_FAIL,
                                    slpp_pkg::ST_REPAIR, slpp_pkg::ST_LOCAL_FAIL,
                                    slpp_pkg::ST_FATAL, slpp_pkg::ST_BLOCKED};

    slpp_pkg::result_t led_expect_q [$];
    slpp_pkg::result_t led_want;
    int unsigned fail_count = 0;
    int unsigned checked_count = 0;
    int unsigned items_sent = 0;
    int unsigned tick_count = 0;
    int unsigned wrap_count = 0;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned stall_request = 0;
    int unsigned stall_left = 0;

    status_led_priority_pattern_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned status_rank(logic [3:0] s);
        case (s)
            slpp_pkg::ST_BOOTING:     return 20;
            slpp_pkg::ST_WIFI:        return 30;
            slpp_pkg::ST_DISCOVER:    return 40;
            slpp_pkg::ST_AUTH:        return 50;
            slpp_pkg::ST_SYNC:        return 60;
            slpp_pkg::ST_HEALTHY:     return 10;
            slpp_pkg::ST_BACKLOG:     return 55;
            slpp_pkg::ST_REMOTE_FAIL: return 80;
            slpp_pkg::ST_LINK_FAIL:   return 75;
            slpp_pkg::ST_FLAPPING:    return 74;
            slpp_pkg::ST_REPAIR:      return 72;
            slpp_pkg::ST_REBOOT:      return 90;
            slpp_pkg::ST_LOCAL_FAIL:  return 85;
            slpp_pkg::ST_FATAL:       return 100;
            slpp_pkg::ST_BLOCKED:     return 70;
            default:                  return 10;
        endcase
    endfunction

    function automatic void take_fault(logic [3:0] s);
        fault_st = s;
        fault_on = 1'b1;
        fault_left = cfg_fault_hold;
    endfunction

    function automatic logic [7:0] dim_channel(int unsigned level);
        int unsigned scale;
        scale = (cfg_brightness == 8'd0) ? 1 : cfg_brightness;
        return 8'((level * scale) / 255);
    endfunction

    function automatic slpp_pkg::result_t predict_led_beat(slpp_pkg::item_t it);
        slpp_pkg::result_t res;
        logic [3:0]  sel;
        int unsigned tri_lvl;
        int unsigned pulse;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        bit          flash;
        bit          slow_on;
        bit          fast_on;
        bit          heart_on;
        r = 0;
        g = 0;
        b = 0;
        case (it.opcode)
            slpp_pkg::OP_TICK:
            begin
                if (slow_ph + 1 >= 2000)
                begin
                    slow_ph = 0;
                    wrap_count++;
                end
                else
                begin
                    slow_ph++;
                end
                fast_ph = (fast_ph + 1 >= 300) ? 0 : fast_ph + 1;
                if (fault_left != 0)
                    fault_left--;
                if (flash_left != 0)
                    flash_left--;
                tick_count++;
            end
            slpp_pkg::OP_SET_BASE:
            begin
                base_st = it.status_code;
                if (it.status_code == slpp_pkg::ST_FATAL)
                    take_fault(slpp_pkg::ST_FATAL);
            end
            slpp_pkg::OP_LATCH:
            begin
                if (it.status_code == slpp_pkg::ST_REMOTE_FAIL ||
                    it.status_code == slpp_pkg::ST_LINK_FAIL ||
                    it.status_code == slpp_pkg::ST_REPAIR ||
                    it.status_code == slpp_pkg::ST_LOCAL_FAIL ||
                    it.status_code == slpp_pkg::ST_FATAL ||
                    it.status_code == slpp_pkg::ST_BLOCKED)
                begin
                    take_fault(it.status_code);
                    if (it.status_code == slpp_pkg::ST_FATAL)
                        base_st = slpp_pkg::ST_FATAL;
                end
            end
            slpp_pkg::OP_CLEAR:
            begin
                if (it.status_code != slpp_pkg::ST_FATAL && fault_on &&
                    fault_st == it.status_code)
                    fault_on = 1'b0;
            end
            slpp_pkg::OP_ACTIVITY:
                flash_left = cfg_flash_hold;
            slpp_pkg::OP_BACKLOG:
                backlog_on = it.backlog_flag;
            default:
                ;
        endcase

        if (fault_on && fault_left == 0 && fault_st != slpp_pkg::ST_FATAL)
            fault_on = 1'b0;

        sel = base_st;
        if (sel == slpp_pkg::ST_HEALTHY && backlog_on)
            sel = slpp_pkg::ST_BACKLOG;
        if (fault_on && fault_left != 0 && status_rank(fault_st) > status_rank(sel))
            sel = fault_st;
        flash = (flash_left != 0) && (status_rank(sel) <= status_rank(slpp_pkg::ST_BACKLOG));

        slow_on = (slow_ph % 1000) < 500;
        fast_on = fast_ph < 150;
        heart_on = (slow_ph < 120) || (slow_ph >= 260 && slow_ph < 380);
        tri_lvl = (slow_ph < 1000) ? slow_ph : 2000 - slow_ph;
        pulse = tri_lvl * 180 / 1000 + 32;

        if (flash)
        begin
            g = 255;
        end
        else
        begin
            case (sel)
                slpp_pkg::ST_BOOTING:
                begin
                    r = pulse;
                    g = pulse;
                    b = pulse;
                end
                slpp_pkg::ST_WIFI:
                    b = slow_on ? 255 : 0;
                slpp_pkg::ST_DISCOVER:
                begin
                    g = pulse;
                    b = pulse;
                end
                slpp_pkg::ST_AUTH:
                begin
                    g = 255;
                    b = 255;
                end
                slpp_pkg::ST_SYNC:
                begin
                    r = pulse;
                    b = pulse;
                end
                slpp_pkg::ST_HEALTHY:
                    g = 255;
                slpp_pkg::ST_BACKLOG:
                begin
                    r = heart_on ? 255 : 20;
                    g = heart_on ? 160 : 12;
                end
                slpp_pkg::ST_REMOTE_FAIL:
                begin
                    r = slow_on ? 255 : 0;
                    g = slow_on ? 80 : 0;
                end
                slpp_pkg::ST_LINK_FAIL:
                begin
                    r = slow_on ? 255 : 0;
                    g = slow_on ? 220 : 0;
                end
                slpp_pkg::ST_FLAPPING:
                begin
                    r = fast_on ? 255 : 0;
                    g = fast_on ? 120 : 40;
                    b = fast_on ? 0 : 90;
                end
                slpp_pkg::ST_REPAIR:
                begin
                    r = slow_on ? 255 : 0;
                    g = slow_on ? 170 : 0;
                end
                slpp_pkg::ST_REBOOT:
                    r = fast_on ? 255 : 0;
                slpp_pkg::ST_LOCAL_FAIL:
                begin
                    r = slow_on ? 255 : 0;
                    g = slow_on ? 24 : 0;
                end
                slpp_pkg::ST_FATAL:
                    r = 255;
                slpp_pkg::ST_BLOCKED:
                begin
                    r = slow_on ? 255 : 0;
                    b = slow_on ? 255 : 0;
                end
                default:
                    ;
            endcase
        end

        res.red = dim_channel(r);
        res.green = dim_channel(g);
        res.blue = dim_channel(b);
        res.shown_status = sel;
        res.flash_active = flash;
        return res;
    endfunction

    task automatic send_led_event(logic [2:0] op, logic [3:0] code, logic flag);
        slpp_pkg::item_t it;
        int unsigned     gap;
        it = '{opcode: op, status_code: code, backlog_flag: flag};
        gap = 0;
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 38 && gap < 12)
                gap++;
        end
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!(item_valid && item_ready));
        led_expect_q.push_back(predict_led_beat(it));
        items_sent++;
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (led_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_led_register(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_led_settings(logic [7:0] bright, logic [19:0] fault_ms,
                                     logic [15:0] flash_ms);
        wait_for_results();
        write_led_register(slpp_pkg::REG_BRIGHTNESS, {24'd0, bright});
        cfg_brightness = bright;
        write_led_register(slpp_pkg::REG_FAULT_HOLD, {12'd0, fault_ms});
        cfg_fault_hold = fault_ms;
        write_led_register(slpp_pkg::REG_FLASH_HOLD, {16'd0, flash_ms});
        cfg_flash_hold = flash_ms;
    endtask

    task automatic test_every_status();
        for (int s = 0; s < 16; s++)
        begin
            if (4'(s) != slpp_pkg::ST_FATAL)
                send_led_event(slpp_pkg::OP_SET_BASE, 4'(s), s[0]);
        end
    endtask

    task automatic test_backlog_and_flash();
        send_led_event(slpp_pkg::OP_SET_BASE, slpp_pkg::ST_HEALTHY, 1'b0);
        send_led_event(slpp_pkg::OP_BACKLOG, ST_UNKNOWN, 1'b1);
        send_led_event(slpp_pkg::OP_ACTIVITY, ST_UNKNOWN, 1'b1);
        send_led_event(slpp_pkg::OP_TICK, ST_UNKNOWN, 1'b1);
        send_led_event(slpp_pkg::OP_BACKLOG, slpp_pkg::ST_BOOTING, 1'b0);
    endtask

    task automatic test_fault_rules();
        send_led_event(slpp_pkg::OP_LATCH, slpp_pkg::ST_HEALTHY, 1'b0);
        send_led_event(slpp_pkg::OP_LATCH, slpp_pkg::ST_LINK_FAIL, 1'b0);
        send_led_event(slpp_pkg::OP_CLEAR, slpp_pkg::ST_REMOTE_FAIL, 1'b0);
        send_led_event(slpp_pkg::OP_CLEAR, slpp_pkg::ST_LINK_FAIL, 1'b1);
        send_led_event(slpp_pkg::OP_LATCH, slpp_pkg::ST_FATAL, 1'b0);
        send_led_event(slpp_pkg::OP_CLEAR, slpp_pkg::ST_FATAL, 1'b0);
        send_led_event(slpp_pkg::OP_SET_BASE, slpp_pkg::ST_HEALTHY, 1'b0);
        send_led_event(OP_SPARE_6, ST_UNKNOWN, 1'b1);
        send_led_event(OP_SPARE_7, slpp_pkg::ST_BOOTING, 1'b0);
    endtask

    task automatic test_zero_holds();
        load_led_settings(8'd0, 20'd0, 16'd0);
        send_led_event(slpp_pkg::OP_LATCH, slpp_pkg::ST_REMOTE_FAIL, 1'b0);
        send_led_event(slpp_pkg::OP_ACTIVITY, slpp_pkg::ST_BOOTING, 1'b0);
        send_led_event(slpp_pkg::OP_TICK, slpp_pkg::ST_BOOTING, 1'b0);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [2:0]  op;
        logic [3:0]  code;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            code = 4'($urandom);
            if (pick < 28)
            begin
                op = slpp_pkg::OP_LATCH;
                if ($urandom_range(3) != 0)
                    code = fault_codes[$urandom_range(5)];
            end
            else if (pick < 44)
            begin
                op = slpp_pkg::OP_CLEAR;
                if ($urandom_range(2) != 0)
                    code = fault_st;
            end
            else if (pick < 62)
            begin
                op = slpp_pkg::OP_SET_BASE;
                if (code == slpp_pkg::ST_FATAL && $urandom_range(3) != 0)
                    code = slpp_pkg::ST_HEALTHY;
            end
            else if (pick < 76)
            begin
                op = slpp_pkg::OP_ACTIVITY;
            end
            else if (pick < 90)
            begin
                op = slpp_pkg::OP_BACKLOG;
            end
            else
            begin
                op = 3'($urandom_range(7));
            end
            send_led_event(op, code, 1'($urandom));
            sent++;
            burst = $urandom_range(32);
            while (burst != 0 && sent < count)
            begin
                send_led_event(slpp_pkg::OP_TICK, 4'($urandom), 1'($urandom));
                sent++;
                burst--;
            end
        end
    endtask

    task automatic test_receiver_stall();
        wait_for_results();
        steady_flow = 1'b1;
        stall_request = 150;
        test_random_traffic(40);
        steady_flow = 1'b0;
        wait_for_results();
    endtask

    task automatic test_steady_stretch();
        load_led_settings(8'($urandom_range(255, 1)), 20'($urandom_range(40)),
                          16'($urandom_range(30)));
        steady_flow = 1'b1;
        test_random_traffic(PHASE_ITEMS);
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else if (steady_flow)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (led_expect_q.size() == 0)
            begin
                $error("result beat with no expectation pending");
                fail_count++;
            end
            else
            begin
                led_want = led_expect_q.pop_front();
                checked_count++;
                if (result.red !== led_want.red)
                begin
                    $error("red: expected %0d, got %0d", led_want.red, result.red);
                    fail_count++;
                end
                if (result.green !== led_want.green)
                begin
                    $error("green: expected %0d, got %0d", led_want.green, result.green);
                    fail_count++;
                end
                if (result.blue !== led_want.blue)
                begin
                    $error("blue: expected %0d, got %0d", led_want.blue, result.blue);
                    fail_count++;
                end
                if (result.shown_status !== led_want.shown_status)
                begin
                    $error("shown_status: expected %0d, got %0d",
                           led_want.shown_status, result.shown_status);
                    fail_count++;
                end
                if (result.flash_active !== led_want.flash_active)
                begin
                    $error("flash_active: expected %0d, got %0d",
                           led_want.flash_active, result.flash_active);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, led_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_every_status();
        test_backlog_and_flash();
        test_fault_rules();
        test_zero_holds();

        load_led_settings(8'd255, 20'd0, 16'd0);
        test_random_traffic(PHASE_ITEMS);
        load_led_settings(8'd1, 20'hFFFFF, 16'hFFFF);
        test_random_traffic(PHASE_ITEMS);
        test_receiver_stall();
        test_steady_stretch();
        for (int p = 0; p < 3; p++)
        begin
            load_led_settings(8'($urandom_range(255, 1)),
                              ($urandom_range(7) == 0) ? 20'($urandom)
                                                       : 20'($urandom_range(60)),
                              16'($urandom_range(40)));
            test_random_traffic(PHASE_ITEMS);
        end

        wait_for_results();
        $display("Covered %0d beats (%0d ticks, %0d slow-phase wraps), %0d results checked",
                 items_sent, tick_count, wrap_count, checked_count);
        $display("Settings swept from zero to full hold times and brightness 0, 1 and 255");
        if (fail_count == 0 && led_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
